// ===== rtl/dsm_pkg.sv =====
package dsm_pkg;

    localparam int CPR_W   = 24;
    localparam int DIA_W   = 10;
    localparam int PER_W   = 10;
    localparam int ELAP_W  = 16;
    localparam int MAG_W   = 17;
    localparam int NUM_W   = 45;
    localparam int DEN_W   = CPR_W + ELAP_W;
    localparam int WHOLE_W = 26;

    localparam int STALE_LIMIT_DEF = 1000;
    localparam int Q_DEPTH_DEF     = 2;

    localparam logic [CPR_W-1:0] CPR_RESET    = 24'd60000;
    localparam logic [DIA_W-1:0] DIA_RESET    = 10'd66;
    localparam logic [PER_W-1:0] PER_RESET    = 10'd10;
    localparam logic             LINV_RESET   = 1'b1;
    localparam logic             RINV_RESET   = 1'b0;

    localparam logic [22:0] K_PI_X1000   = 23'd3142;
    localparam logic [22:0] K_RPM_X100   = 23'd6000000;
    localparam logic [9:0]  K_SPD_X100   = 10'd100;
    localparam logic [9:0]  K_ONE        = 10'd1;
    localparam logic [22:0] K_ONE_WIDE   = 23'd1;

    // ceil(2^37 / 100): exact divide by 100 for inputs below about 4.9e9
    localparam logic [31:0] K_DIV100_MAGIC = 32'h51EB_851F;
    localparam int          K_DIV100_SHIFT = 37;
    localparam logic [31:0] K_HALF_HUNDRED = 32'd50;

    localparam logic [1:0] STAT_SKIP   = 2'd0;
    localparam logic [1:0] STAT_SAMPLE = 2'd1;
    localparam logic [1:0] STAT_RESET  = 2'd2;

    localparam logic [2:0] REG_CPR  = 3'd0;
    localparam logic [2:0] REG_DIA  = 3'd1;
    localparam logic [2:0] REG_PER  = 3'd2;
    localparam logic [2:0] REG_LINV = 3'd3;
    localparam logic [2:0] REG_RINV = 3'd4;

    typedef struct packed {
        logic [CPR_W-1:0] cpr;
        logic [DIA_W-1:0] dia;
        logic [PER_W-1:0] period;
        logic             linv;
        logic             rinv;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       ltot;
        logic [31:0]       rtot;
        logic              lneg;
        logic [MAG_W-1:0]  lmag;
        logic              rneg;
        logic [MAG_W-1:0]  rmag;
        logic [ELAP_W-1:0] elapsed;
    } t_job;

endpackage

// ===== rtl/dsm_fifo.sv =====
module dsm_fifo
    import dsm_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL = (AW+1)'(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/dsm_front.sv =====
module dsm_front
    import dsm_pkg::*;
#(
    parameter int STALE_LIMIT_MS = STALE_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_left_counter,
    input  logic [15:0] i_right_counter,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);
    logic [31:0] r_last;
    logic [15:0] r_lbase;
    logic [15:0] r_rbase;
    logic [31:0] r_lsum;
    logic [31:0] r_rsum;

    logic [31:0] w_elapsed;
    logic        w_reset;
    logic        w_skip;
    logic [15:0] w_ld;
    logic [15:0] w_rd;
    logic [31:0] w_lsum;
    logic [31:0] w_rsum;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        w_elapsed = i_now_ms - r_last;
        w_reset   = i_action || (w_elapsed > 32'(STALE_LIMIT_MS));
        w_skip    = w_elapsed < {{(32-PER_W){1'b0}}, i_cfg.period};
        w_ld      = i_left_counter - r_lbase;
        w_rd      = i_right_counter - r_rbase;
        if (i_cfg.linv) begin
            w_ld = 16'd0 - w_ld;
        end
        if (i_cfg.rinv) begin
            w_rd = 16'd0 - w_rd;
        end
        w_lsum = r_lsum + {{16{w_ld[15]}}, w_ld};
        w_rsum = r_rsum + {{16{w_rd[15]}}, w_rd};

        o_job.elapsed = w_elapsed[ELAP_W-1:0];
        o_job.lneg    = w_ld[15];
        o_job.rneg    = w_rd[15];
        // magnitude of the delta; the most negative delta gives 32768, which still fits in 16 of the 17 bits
        o_job.lmag    = w_ld[15] ? (17'h10000 - {1'b0, w_ld}) : {1'b0, w_ld};
        o_job.rmag    = w_rd[15] ? (17'h10000 - {1'b0, w_rd}) : {1'b0, w_rd};
        if (w_reset) begin
            o_job.status = STAT_RESET;
            o_job.ltot   = '0;
            o_job.rtot   = '0;
        end else if (w_skip) begin
            o_job.status = STAT_SKIP;
            o_job.ltot   = r_lsum;
            o_job.rtot   = r_rsum;
        end else begin
            o_job.status = STAT_SAMPLE;
            o_job.ltot   = w_lsum;
            o_job.rtot   = w_rsum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_lbase <= '0;
            r_rbase <= '0;
            r_lsum  <= '0;
            r_rsum  <= '0;
        end else if (o_push && (w_reset || !w_skip)) begin
            r_last  <= i_now_ms;
            r_lbase <= i_left_counter;
            r_rbase <= i_right_counter;
            r_lsum  <= w_reset ? '0 : w_lsum;
            r_rsum  <= w_reset ? '0 : w_rsum;
        end
    end
endmodule

// ===== rtl/dsm_div.sv =====
module dsm_div
    import dsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_nq;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_try;
    logic             w_ge;

    assign w_try  = {r_rem[DEN_W-1:0], r_nq[NUM_W-1]};
    assign w_ge   = w_try >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_nq;

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_try - {1'b0, r_den}) : w_try;
            r_nq  <= {r_nq[NUM_W-2:0], w_ge};
        end
    end
endmodule

// ===== rtl/dsm_back.sv =====
module dsm_back
    import dsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_empty,
    input  t_job               i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [31:0]        o_left_total,
    output logic [31:0]        o_right_total,
    output logic [31:0]        o_left_speed_x100,
    output logic [31:0]        o_right_speed_x100,
    output logic [31:0]        o_left_rpm_centi,
    output logic [31:0]        o_right_rpm_centi,
    output logic [WHOLE_W-1:0] o_left_speed_whole,
    output logic [WHOLE_W-1:0] o_right_speed_whole
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_M3   = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_WAIT = 4'd5;
    localparam logic [3:0] S_OUT  = 4'd6;
    localparam logic [3:0] S_W1   = 4'd7;
    localparam logic [3:0] S_W2   = 4'd8;
    localparam logic [3:0] S_W3   = 4'd9;

    localparam logic [2:0] J_LSPD   = 3'd0;
    localparam logic [2:0] J_LRPM   = 3'd1;
    localparam logic [2:0] J_RSPD   = 3'd2;
    localparam logic [2:0] J_RRPM   = 3'd3;
    localparam logic [2:0] J_LWHOLE = 3'd4;
    localparam logic [2:0] J_RWHOLE = 3'd5;

    logic [3:0]         r_state;
    logic [2:0]         r_jn;
    t_job               r_job;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_prod;
    logic [31:0]        r_lspd;
    logic [31:0]        r_rspd;
    logic [31:0]        r_lrpm;
    logic [31:0]        r_rrpm;
    logic [WHOLE_W-1:0] r_lwhole;
    logic [WHOLE_W-1:0] r_rwhole;
    logic               r_ovalid;
    logic               r_wneg;
    logic [31:0]        r_wabs;
    logic [63:0]        r_wprod;

    logic [MAG_W-1:0]   w_a;
    logic [22:0]        w_f1;
    logic [9:0]         w_f2;
    logic [9:0]         w_f3;
    logic               w_neg;
    logic [DEN_W-1:0]   w_divisor;
    logic               w_start;
    logic               w_done;
    logic [NUM_W-1:0]   w_quot;
    logic [31:0]        w_sat;
    logic [31:0]        w_wsel;
    logic [WHOLE_W-1:0] w_wq;
    logic               w_emit;

    dsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (r_prod + NUM_W'(w_divisor >> 1)),
        .i_den   (w_divisor),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign w_start = (r_state == S_DIV) && (w_divisor != '0);
    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign w_emit  = (r_state == S_OUT) && (!r_ovalid || !i_out_stall);

    always_comb begin
        w_a       = '0;
        w_f1      = K_ONE_WIDE;
        w_f2      = K_ONE;
        w_f3      = K_ONE;
        w_neg     = 1'b0;
        w_divisor = r_den;
        case (r_jn)
            J_LSPD: begin
                w_a   = r_job.lmag;
                w_f1  = K_PI_X1000;
                w_f2  = i_cfg.dia;
                w_f3  = K_SPD_X100;
                w_neg = r_job.lneg;
            end
            J_LRPM: begin
                w_a   = r_job.lmag;
                w_f1  = K_RPM_X100;
                w_neg = r_job.lneg;
            end
            J_RSPD: begin
                w_a   = r_job.rmag;
                w_f1  = K_PI_X1000;
                w_f2  = i_cfg.dia;
                w_f3  = K_SPD_X100;
                w_neg = r_job.rneg;
            end
            J_RRPM: begin
                w_a   = r_job.rmag;
                w_f1  = K_RPM_X100;
                w_neg = r_job.rneg;
            end
            default: begin
                w_a = '0;
            end
        endcase

        // quotient clamps to the signed 32-bit range
        if (!w_neg) begin
            w_sat = (w_quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : w_quot[31:0];
        end else begin
            w_sat = (w_quot > NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                     : (32'd0 - w_quot[31:0]);
        end

        w_wsel = (r_jn == J_LWHOLE) ? r_lspd : r_rspd;
        w_wq   = r_wneg ? (WHOLE_W'(0) - r_wprod[K_DIV100_SHIFT +: WHOLE_W])
                        : r_wprod[K_DIV100_SHIFT +: WHOLE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_jn     <= J_LSPD;
            r_ovalid <= 1'b0;
            r_lspd   <= '0;
            r_rspd   <= '0;
            r_lrpm   <= '0;
            r_rrpm   <= '0;
            r_lwhole <= '0;
            r_rwhole <= '0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_jn <= J_LSPD;
                        case (i_job.status)
                            STAT_SAMPLE: r_state <= S_M1;
                            STAT_RESET: begin
                                r_lspd   <= '0;
                                r_rspd   <= '0;
                                r_lrpm   <= '0;
                                r_rrpm   <= '0;
                                r_lwhole <= '0;
                                r_rwhole <= '0;
                                r_state  <= S_OUT;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_DIV;
                S_DIV: begin
                    if (w_divisor == '0) begin
                        // no denominator: speed and rpm read zero
                        case (r_jn)
                            J_LSPD:  r_lspd <= '0;
                            J_LRPM:  r_lrpm <= '0;
                            J_RSPD:  r_rspd <= '0;
                            J_RRPM:  r_rrpm <= '0;
                            default: r_lrpm <= r_lrpm;
                        endcase
                        r_jn    <= r_jn + 1'b1;
                        r_state <= (r_jn == J_RRPM) ? S_W1 : S_M1;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        case (r_jn)
                            J_LSPD:   r_lspd   <= w_sat;
                            J_LRPM:   r_lrpm   <= w_sat;
                            J_RSPD:   r_rspd   <= w_sat;
                            J_RRPM:   r_rrpm   <= w_sat;
                            default:  r_lrpm   <= r_lrpm;
                        endcase
                        r_jn    <= r_jn + 1'b1;
                        r_state <= (r_jn == J_RRPM) ? S_W1 : S_M1;
                    end
                end
                S_W1: r_state <= S_W2;
                S_W2: r_state <= S_W3;
                S_W3: begin
                    if (r_jn == J_LWHOLE) begin
                        r_lwhole <= w_wq;
                        r_jn     <= J_RWHOLE;
                        r_state  <= S_W1;
                    end else begin
                        r_rwhole <= w_wq;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_den <= DEN_W'(i_cfg.cpr) * DEN_W'(i_job.elapsed);
        end
        case (r_state)
            S_M1:    r_prod <= NUM_W'(w_a) * NUM_W'(w_f1);
            S_M2:    r_prod <= r_prod * NUM_W'(w_f2);
            S_M3:    r_prod <= r_prod * NUM_W'(w_f3);
            default: r_prod <= r_prod;
        endcase
        // whole mm/s: magnitude plus half, then reciprocal multiply by 1/100
        if (r_state == S_W1) begin
            r_wneg <= w_wsel[31];
            r_wabs <= (w_wsel[31] ? (32'd0 - w_wsel) : w_wsel) + K_HALF_HUNDRED;
        end
        if (r_state == S_W2) begin
            r_wprod <= 64'(r_wabs) * 64'(K_DIV100_MAGIC);
        end
        if (w_emit) begin
            o_status            <= r_job.status;
            o_left_total        <= r_job.ltot;
            o_right_total       <= r_job.rtot;
            o_left_speed_x100   <= r_lspd;
            o_right_speed_x100  <= r_rspd;
            o_left_rpm_centi    <= r_lrpm;
            o_right_rpm_centi   <= r_rrpm;
            o_left_speed_whole  <= r_lwhole;
            o_right_speed_whole <= r_rwhole;
        end
    end

    assign o_out_valid = r_ovalid;
endmodule

// ===== rtl/dual_encoder_speed_meter.sv =====
// Speed meter for two quadrature wheel encoders. Each input word carries a
// millisecond timestamp and both raw 16-bit counters; each gives exactly one
// result word with status (skip, sample, reset), running totals, speed and rpm
// in hundredths and whole mm/s. A front stage classifies words and updates the
// totals and feeds a two-word queue; the back stage works out the
// four speed and rpm quotients on one shared restoring divider at one bit a
// cycle, then rounds both speeds to whole mm/s by reciprocal multiplication.
// For a sampled word the back stage takes the word, runs each of the four
// quotients as three multiply steps, a divider start and the divide, works out
// the whole speeds and then presents the result. With a zero denominator the
// divide is skipped; skip and reset words go straight to the output. Output
// stalls hold the back stage until the word is taken. The input stalls while the queue
// holds two waiting words. Registers sit on an APB port at byte offsets
// 0,4,8,12,16.
module dual_encoder_speed_meter
    import dsm_pkg::*;
#(
    parameter int STALE_LIMIT_MS = STALE_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [31:0]        i_now_ms,
    input  logic [15:0]        i_left_counter,
    input  logic [15:0]        i_right_counter,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [31:0]        o_left_total,
    output logic [31:0]        o_right_total,
    output logic [31:0]        o_left_speed_x100,
    output logic [31:0]        o_right_speed_x100,
    output logic [31:0]        o_left_rpm_centi,
    output logic [31:0]        o_right_rpm_centi,
    output logic [WHOLE_W-1:0] o_left_speed_whole,
    output logic [WHOLE_W-1:0] o_right_speed_whole
);
    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cpr    <= CPR_RESET;
            r_cfg.dia    <= DIA_RESET;
            r_cfg.period <= PER_RESET;
            r_cfg.linv   <= LINV_RESET;
            r_cfg.rinv   <= RINV_RESET;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_CPR:  r_cfg.cpr    <= pwdata[CPR_W-1:0];
                REG_DIA:  r_cfg.dia    <= pwdata[DIA_W-1:0];
                REG_PER:  r_cfg.period <= pwdata[PER_W-1:0];
                REG_LINV: r_cfg.linv   <= pwdata[0];
                REG_RINV: r_cfg.rinv   <= pwdata[0];
                default:  r_cfg.rinv   <= r_cfg.rinv;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CPR:  prdata = {{(32-CPR_W){1'b0}}, r_cfg.cpr};
            REG_DIA:  prdata = {{(32-DIA_W){1'b0}}, r_cfg.dia};
            REG_PER:  prdata = {{(32-PER_W){1'b0}}, r_cfg.period};
            REG_LINV: prdata = {31'd0, r_cfg.linv};
            REG_RINV: prdata = {31'd0, r_cfg.rinv};
            default:  prdata = '0;
        endcase
    end

    dsm_front #(
        .STALE_LIMIT_MS (STALE_LIMIT_MS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_now_ms        (i_now_ms),
        .i_left_counter  (i_left_counter),
        .i_right_counter (i_right_counter),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_job           (w_push_job)
    );

    dsm_fifo #(
        .W     ($bits(t_job)),
        .DEPTH (Q_DEPTH_DEF)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    dsm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (r_cfg),
        .i_empty             (w_empty),
        .i_job               (w_pop_job),
        .o_pop               (w_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_left_total        (o_left_total),
        .o_right_total       (o_right_total),
        .o_left_speed_x100   (o_left_speed_x100),
        .o_right_speed_x100  (o_right_speed_x100),
        .o_left_rpm_centi    (o_left_rpm_centi),
        .o_right_rpm_centi   (o_right_rpm_centi),
        .o_left_speed_whole  (o_left_speed_whole),
        .o_right_speed_whole (o_right_speed_whole)
    );
endmodule

// ===== dv/dual_encoder_speed_meter_test.sv =====
`timescale 1ns / 100ps

module dual_encoder_speed_meter_test;
    import dsm_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] ltot, rtot, lspd, rspd, lrpm, rrpm;
        logic [25:0] lwhole, rwhole;
    } t_meter_word;

    class speed_scoreboard;
        bit [23:0] cpr;
        bit [9:0]  dia, period;
        bit        linv, rinv;
        bit [31:0] last_t;
        bit [15:0] lbase, rbase;
        bit [31:0] lsum, rsum, lspd, rspd, lrpm, rrpm;
        t_meter_word pending[$];
        int errors;
        int n_sample, n_skip, n_reset;

        function void clear_state();
            cpr = CPR_RESET; dia = DIA_RESET; period = PER_RESET;
            linv = LINV_RESET; rinv = RINV_RESET;
            last_t = 0; lbase = 0; rbase = 0;
            lsum = 0; rsum = 0; lspd = 0; rspd = 0; lrpm = 0; rrpm = 0;
        endfunction

        function bit [31:0] rounded_quot(bit neg, bit [63:0] mag, bit [63:0] den);
            bit [63:0] q;
            if (den == 0) return 0;
            q = (mag + den / 2) / den;
            if (!neg) return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            if (q > 64'h80000000) q = 64'h80000000;
            return -q[31:0];
        endfunction

        function bit [25:0] to_whole(bit [31:0] v);
            bit [31:0] m, q;
            m = v[31] ? -v : v;
            q = 32'((64'(m) + 50) / 100);
            return v[31] ? 26'(-q) : 26'(q);
        endfunction

        function void channel(bit [15:0] cnt, inout bit [15:0] base, input bit inv,
                              bit [31:0] el, inout bit [31:0] sum, spd, rpm);
            bit [15:0] d;
            bit neg;
            bit [63:0] mag, den;
            d = cnt - base;
            base = cnt;
            if (inv) d = -d;
            neg = d[15];
            mag = neg ? 64'(17'h10000 - d) : 64'(d);
            sum = sum + (neg ? -mag[31:0] : mag[31:0]);
            den = 64'(cpr) * 64'(el);
            spd = rounded_quot(neg, mag * 3142 * dia * 100, den);
            rpm = rounded_quot(neg, mag * 6000000, den);
        endfunction

        function void note_input(bit act, bit [31:0] now, bit [15:0] lc, bit [15:0] rc);
            bit [31:0] el;
            t_meter_word w;
            el = now - last_t;
            if (act || el > 1000) begin
                lbase = lc; rbase = rc; last_t = now;
                lsum = 0; rsum = 0; lspd = 0; rspd = 0; lrpm = 0; rrpm = 0;
                w.status = STAT_RESET; n_reset++;
            end else if (el < period) begin
                w.status = STAT_SKIP; n_skip++;
            end else begin
                last_t = now;
                channel(lc, lbase, linv, el, lsum, lspd, lrpm);
                channel(rc, rbase, rinv, el, rsum, rspd, rrpm);
                w.status = STAT_SAMPLE; n_sample++;
            end
            w.ltot = lsum; w.rtot = rsum; w.lspd = lspd; w.rspd = rspd;
            w.lrpm = lrpm; w.rrpm = rrpm;
            w.lwhole = to_whole(lspd); w.rwhole = to_whole(rspd);
            pending.push_back(w);
        endfunction

        function void cmp(string f, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $error("%s: expected %h, got %h", f, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_meter_word a);
            t_meter_word e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", 32'(e.status), 32'(a.status));
            cmp("left_total", e.ltot, a.ltot);
            cmp("right_total", e.rtot, a.rtot);
            cmp("left_speed_x100", e.lspd, a.lspd);
            cmp("right_speed_x100", e.rspd, a.rspd);
            cmp("left_rpm_centi", e.lrpm, a.lrpm);
            cmp("right_rpm_centi", e.rrpm, a.rrpm);
            cmp("left_speed_whole", 32'(e.lwhole), 32'(a.lwhole));
            cmp("right_speed_whole", 32'(e.rwhole), 32'(a.rwhole));
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic pready;
    logic i_in_valid = 0, o_in_stall;
    logic i_action = 0;
    logic [31:0] i_now_ms = 0;
    logic [15:0] i_left_counter = 0, i_right_counter = 0;
    logic o_out_valid, i_out_stall = 0;
    logic [1:0] o_status;
    logic [31:0] o_left_total, o_right_total, o_left_speed_x100, o_right_speed_x100;
    logic [31:0] o_left_rpm_centi, o_right_rpm_centi;
    logic [25:0] o_left_speed_whole, o_right_speed_whole;

    speed_scoreboard sb = new();
    bit [31:0] clock_ms;
    bit [15:0] lpos, rpos;
    bit hold_off_rx;

    dual_encoder_speed_meter dut (.*);

    always #2 i_clk = ~i_clk;

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                t_meter_word w;
                w.status = o_status; w.ltot = o_left_total; w.rtot = o_right_total;
                w.lspd = o_left_speed_x100; w.rspd = o_right_speed_x100;
                w.lrpm = o_left_rpm_centi; w.rrpm = o_right_rpm_centi;
                w.lwhole = o_left_speed_whole; w.rwhole = o_right_speed_whole;
                sb.check_result(w);
            end
        end
    end

    initial begin
        int g;
        forever begin
            @(posedge i_clk);
            if (hold_off_rx) begin
                i_out_stall <= 1;
                repeat (2000) @(posedge i_clk);
                hold_off_rx = 0;
                i_out_stall <= 0;
            end else begin
                g = gap_len();
                if (g > 0 && $urandom_range(0, 2) == 0) begin
                    i_out_stall <= 1;
                    repeat (g) @(posedge i_clk);
                end
                i_out_stall <= 0;
            end
        end
    end

    // valid stays high after an accepted word until a gap or a drain drops it
    task automatic send_word(bit act, bit [31:0] now, bit [15:0] lc, bit [15:0] rc,
                             bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1; i_action <= act; i_now_ms <= now;
        i_left_counter <= lc; i_right_counter <= rc;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(act, now, lc, rc);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, bit [31:0] v);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_CPR:  sb.cpr = v[23:0];
            REG_DIA:  sb.dia = v[9:0];
            REG_PER:  sb.period = v[9:0];
            REG_LINV: sb.linv = v[0];
            default:  sb.rinv = v[0];
        endcase
    endtask

    // steps near the period, small counter moves; some resets, stale gaps, jumps
    task automatic motion_word(bit gaps);
        int r;
        bit [31:0] dt;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_word(1, clock_ms, 16'($urandom), 16'($urandom), gaps);
            return;
        end
        if (r < 6) dt = $urandom_range(1001, 5000);
        else if (r < 15) dt = $urandom_range(0, sb.period);
        else dt = $urandom_range(sb.period, sb.period + 50);
        clock_ms += dt;
        if ($urandom_range(0, 9) == 0) begin
            lpos = 16'($urandom); rpos = 16'($urandom);
        end else begin
            lpos += 16'($urandom_range(0, 400) - 200);
            rpos += 16'($urandom_range(0, 400) - 200);
        end
        send_word(0, clock_ms, lpos, rpos, gaps);
    endtask

    initial begin
        int k;
        sb.clear_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: counter extremes, wraps, most negative delta, stale, request
        send_word(0, 5, 16'h0010, 16'h0010, 0);
        send_word(0, 10, 16'h8000, 16'h8000, 0);
        send_word(0, 20, 16'h0000, 16'h0000, 0);
        send_word(0, 30, 16'h7FFF, 16'hFFFF, 0);
        send_word(0, 1030, 16'hFFFF, 16'h0001, 0);
        send_word(1, 1031, 16'h1234, 16'h4321, 0);
        send_word(0, 1041, 16'h1334, 16'h4221, 0);
        send_word(0, 2041, 16'h0000, 16'h0000, 0);
        send_word(0, 32'hFFFF_FFF0, 0, 0, 0);
        send_word(0, 32'h0000_0005, 16'h0100, 16'hFF00, 0);
        send_word(0, 32'h0000_03F0, 16'hFFFF, 16'h8000, 0);
        drain();
        write_reg(REG_CPR, 1); write_reg(REG_DIA, 1023); write_reg(REG_PER, 1);
        write_reg(REG_LINV, 0); write_reg(REG_RINV, 1);
        send_word(1, 100, 0, 0, 0);
        send_word(0, 101, 16'h7FFF, 16'h8000, 0);
        send_word(0, 102, 16'hFFFF, 16'h0000, 0);
        send_word(0, 103, 16'h8000, 16'h8000, 0);
        drain();
        write_reg(REG_CPR, 24'hFFFFFF); write_reg(REG_PER, 1000);
        send_word(0, 1103, 16'h8000, 16'h0001, 0);
        send_word(0, 2103, 16'h0001, 16'h8000, 0);
        drain();
        write_reg(REG_PER, 0);
        send_word(0, 2103, 16'h0100, 16'h0100, 0);
        drain();
        write_reg(REG_PER, 1023);
        send_word(0, 2500, 16'h0100, 16'h0100, 0);
        send_word(0, 3500, 16'h0200, 16'h0200, 0);
        drain();

        clock_ms = 5000;
        for (k = 0; k < 1100; k++) begin
            if (k % 150 == 0) begin
                drain();
                write_reg(REG_CPR, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24'hFFFFFF)
                          : $urandom_range(1, 5000));
                write_reg(REG_DIA, $urandom_range(1, 1023));
                write_reg(REG_PER, $urandom_range(1, 40));
                write_reg(REG_LINV, $urandom_range(0, 1));
                write_reg(REG_RINV, $urandom_range(0, 1));
                clock_ms = $urandom;
                send_word(1, clock_ms, lpos, rpos, 0);
            end
            if (k == 300) hold_off_rx = 1;
            if (k == 600) drain();
            if (k < 1080 && $urandom_range(0, 19) == 0) begin
                send_word(1'($urandom_range(0, 1)), $urandom, 16'($urandom),
                          16'($urandom), 1);
            end else begin
                motion_word(k < 250 || k > 350);
            end
        end
        drain();
        $display("covered %0d sampled, %0d skipped, %0d reset words",
                 sb.n_sample, sb.n_skip, sb.n_reset);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dual_encoder_speed_meter verification clean");
        else
            $display("dual_encoder_speed_meter verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("dual_encoder_speed_meter verification failed");
        $finish;
    end

endmodule
